>>> rtl/core/sai_pkg.sv
// ----------------------------------------------------------------------------
// sai_pkg
// Shared types and codes for the safety arm interlock.
// ----------------------------------------------------------------------------
`default_nettype none

package sai_pkg;

    localparam logic [1:0] ST_BOOT     = 2'd0;
    localparam logic [1:0] ST_DISARMED = 2'd1;
    localparam logic [1:0] ST_ACTIVE   = 2'd2;
    localparam logic [1:0] ST_STOPPED  = 2'd3;

    localparam int RB_NOT_READY = 0;
    localparam int RB_OFFLINE   = 1;
    localparam int RB_ESTOP     = 2;
    localparam int RB_TASK      = 3;
    localparam int RB_DEVICE    = 4;
    localparam int RB_DISARMED  = 5;
    localparam int RB_REARM     = 6;
    localparam int RB_INVALID   = 7;

    localparam logic [7:0] REASONS_RESET   = 8'(1 << RB_NOT_READY);
    localparam logic [7:0] REASONS_INVALID = 8'(1 << RB_INVALID);

    typedef struct packed {
        logic sample_valid;
        logic init_done;
        logic link_online;
        logic estop;
        logic tasks_healthy;
        logic devices_healthy;
        logic enable_request;
        logic safe_position;
        logic arm_event;
    } sample_t;

    typedef struct packed {
        logic        changed;
        logic [1:0]  safety_state;
        logic [7:0]  reason_bits;
        logic        output_allowed;
        logic [31:0] transitions;
    } result_t;

    typedef struct packed {
        logic [1:0] state;
        logic [7:0] reasons;
        logic       permitted;
        logic       safe_seen;
    } ilk_state_t;

    typedef struct packed {
        ilk_state_t nxt;
        logic       changed;
    } decision_t;

endpackage

`default_nettype wire

>>> rtl/core/sai_ifs.sv
// ----------------------------------------------------------------------------
// sai_ifs
// Valid/ready channels for samples, results and the config register.
// ----------------------------------------------------------------------------
`default_nettype none

interface sai_sample_if import sai_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sai_result_if import sai_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sai_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sai_decide.sv
// ----------------------------------------------------------------------------
// sai_decide
// Fault mask, rearm qualification and next-state decision for one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module sai_decide
    import sai_pkg::*;
(
    input  var sample_t    sample,
    input  var logic       require_rearm,
    input  var ilk_state_t cur,
    output decision_t      dec
);

    logic [7:0] faults;
    logic       faulty;
    logic       safe_upd;
    ilk_state_t nxt;

    always_comb
    begin
        faults                = '0;
        faults[RB_NOT_READY]  = !sample.init_done;
        faults[RB_OFFLINE]    = !sample.link_online;
        faults[RB_ESTOP]      = sample.estop;
        faults[RB_TASK]       = !sample.tasks_healthy;
        faults[RB_DEVICE]     = !sample.devices_healthy;
        faulty                = (faults != 8'd0);

        if (!require_rearm || faulty)
        begin
            safe_upd = 1'b0;
        end
        else if (!sample.enable_request)
        begin
            safe_upd = sample.safe_position;
        end
        else if (!sample.safe_position)
        begin
            safe_upd = 1'b0;
        end
        else
        begin
            safe_upd = cur.safe_seen;
        end

        nxt.reasons   = faults;
        nxt.safe_seen = safe_upd;

        if (!sample.sample_valid)
        begin
            nxt.state     = ST_STOPPED;
            nxt.reasons   = REASONS_INVALID;
            nxt.safe_seen = 1'b0;
        end
        else if (!faulty && sample.enable_request && (cur.permitted || !require_rearm))
        begin
            nxt.state = ST_ACTIVE;
        end
        else if (!faulty && safe_upd && sample.safe_position && sample.enable_request
                 && sample.arm_event)
        begin
            nxt.state     = ST_ACTIVE;
            nxt.safe_seen = 1'b0;
        end
        else if (faults[RB_NOT_READY])
        begin
            nxt.state = ST_DISARMED;
        end
        else if (!faulty)
        begin
            nxt.state                 = ST_DISARMED;
            nxt.reasons[RB_DISARMED]  = 1'b1;
            nxt.reasons[RB_REARM]     = sample.enable_request;
        end
        else
        begin
            nxt.state = ST_STOPPED;
        end

        nxt.permitted = (nxt.state == ST_ACTIVE);

        dec.nxt     = nxt;
        dec.changed = (nxt.state != cur.state) || (nxt.reasons != cur.reasons)
                      || (nxt.permitted != cur.permitted);
    end

endmodule

`default_nettype wire

>>> rtl/core/safety_arm_interlock.sv
// ----------------------------------------------------------------------------
// safety_arm_interlock
// Arming interlock: per-sample fault mask and boot/disarmed/active/stopped
// state with optional explicit rearm.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch  - one request per control sample (health flags, operator
//                controls). Accepted on valid && ready.
//   result_ch  - exactly one result per sample, in order: changed flag,
//                state, reason mask, output permission, transition count.
//   cfg_ch     - writes require_rearm; write only while no sample is in
//                flight. Always ready.
//   A sample passes through the input register, then the result register.
//   Throughput is one sample per cycle while result_ch does not stall,
//   set by the single state-update pass between the two registers.
//   When result_ch stalls, the result register holds and the input register
//   fills; sample_ch.ready drops only when both are occupied.
//   Reset: state boot, reasons not-ready, permission and rearm qualification
//   cleared, count zero, require_rearm = 1, both pipeline stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module safety_arm_interlock
    import sai_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    sai_sample_if.sink   sample_ch,
    sai_result_if.source result_ch,
    sai_cfg_if.sink      cfg_ch
);

    logic       rearm_reg;
    logic       s1_valid_reg;
    sample_t    s1_data_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    ilk_state_t state_reg;
    logic [31:0] count_reg;
    logic [31:0] count_next;
    decision_t  dec;
    logic       out_free;
    logic       advance;

    assign cfg_ch.ready    = 1'b1;
    assign out_free        = !out_valid_reg || result_ch.ready;
    assign advance         = s1_valid_reg && out_free;
    assign sample_ch.ready = !s1_valid_reg || out_free;
    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_data_reg;

    sai_decide u_decide (
        .sample        (s1_data_reg),
        .require_rearm (rearm_reg),
        .cur           (state_reg),
        .dec           (dec)
    );

    assign count_next = count_reg + {31'd0, dec.changed};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rearm_reg <= 1'b1;
        end
        else if (cfg_ch.valid)
        begin
            rearm_reg <= cfg_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_ch.valid && sample_ch.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ch.valid && sample_ch.ready)
        begin
            s1_data_reg <= sample_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.state     <= ST_BOOT;
            state_reg.reasons   <= REASONS_RESET;
            state_reg.permitted <= 1'b0;
            state_reg.safe_seen <= 1'b0;
            count_reg           <= '0;
            out_valid_reg       <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= dec.nxt;
            count_reg     <= count_next;
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.changed        <= dec.changed;
            out_data_reg.safety_state   <= dec.nxt.state;
            out_data_reg.reason_bits    <= dec.nxt.reasons;
            out_data_reg.output_allowed <= dec.nxt.permitted;
            out_data_reg.transitions    <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_allowed_iff_active: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.permitted == (state_reg.state == ST_ACTIVE))
        else $error("permission out of step with active state");

    a_boot_not_reentered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.state != ST_BOOT) |=> (state_reg.state != ST_BOOT))
        else $error("boot state re-entered");

    a_invalid_forces_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !s1_data_reg.sample_valid) |=>
        (state_reg.state == ST_STOPPED && state_reg.reasons == REASONS_INVALID
         && !state_reg.safe_seen))
        else $error("invalid sample did not force stop");

    a_count_tracks_changes: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (count_reg == $past(count_reg) + {31'd0, $past(dec.changed)}))
        else $error("transition count mismatch");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_data_reg.safety_state == state_reg.state
                     && out_data_reg.transitions == count_reg))
        else $error("result register out of step with state");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for safety_arm_interlock. A directed table, then random arming
// sequences with faults and noise, under both rearm settings. Sample and
// result channels get random gaps. Results are checked against an
// in-bench model of the interlock, or against fixed values for typed rows.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import sai_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

    typedef struct {
        row_kind_e kind;
        sample_t   smp;
        logic      wr_val;
        logic      typed;
        result_t   want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic calm;

    sai_sample_if sample_ch ();
    sai_result_if result_ch ();
    sai_cfg_if    cfg_ch ();

    safety_arm_interlock u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    // interlock model state
    logic [1:0]  m_state;
    logic [7:0]  m_reasons;
    logic        m_perm;
    logic        m_safe_seen;
    logic        m_rearm;
    logic [31:0] m_count;

    result_t     pending_results[$];
    stim_row_t   plan[$];
    int          mismatches;
    int          n_samples;
    int          n_results;
    int          n_writes;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic result_t interlock_step(sample_t s);
        logic [7:0] rs;
        logic [1:0] st;
        logic       perm;
        result_t    r;
        rs = '0;
        if (!s.sample_valid)
        begin
            m_safe_seen = 1'b0;
            st = ST_STOPPED;
            rs = REASONS_INVALID;
        end
        else
        begin
            rs[RB_NOT_READY] = !s.init_done;
            rs[RB_OFFLINE]   = !s.link_online;
            rs[RB_ESTOP]     = s.estop;
            rs[RB_TASK]      = !s.tasks_healthy;
            rs[RB_DEVICE]    = !s.devices_healthy;
            if (!m_rearm || rs != 8'd0)
                m_safe_seen = 1'b0;
            else if (!s.enable_request)
                m_safe_seen = s.safe_position;
            else if (!s.safe_position)
                m_safe_seen = 1'b0;
            if (rs == 8'd0 && s.enable_request && (m_perm || !m_rearm))
                st = ST_ACTIVE;
            else if (rs == 8'd0 && m_safe_seen && s.safe_position && s.enable_request
                     && s.arm_event)
            begin
                st = ST_ACTIVE;
                m_safe_seen = 1'b0;
            end
            else if (rs[RB_NOT_READY])
                st = ST_DISARMED;
            else if (rs == 8'd0)
            begin
                st = ST_DISARMED;
                rs[RB_DISARMED] = 1'b1;
                rs[RB_REARM]    = s.enable_request;
            end
            else
                st = ST_STOPPED;
        end
        perm = (st == ST_ACTIVE);
        r.changed = (st != m_state) || (rs != m_reasons) || (perm != m_perm);
        if (r.changed)
        begin
            m_state   = st;
            m_reasons = rs;
            m_perm    = perm;
            m_count   = m_count + 32'd1;
        end
        r.safety_state   = m_state;
        r.reason_bits    = m_reasons;
        r.output_allowed = m_perm;
        r.transitions    = m_count;
        return r;
    endfunction

    function automatic stim_row_t row_smp(logic [8:0] bits);
        stim_row_t r;
        r.kind   = ROW_SAMPLE;
        r.smp    = sample_t'(bits);
        r.wr_val = 1'b0;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic stim_row_t row_known(logic [8:0] bits, result_t want);
        stim_row_t r;
        r = row_smp(bits);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic stim_row_t row_wr(logic v);
        stim_row_t r;
        r = row_smp(9'd0);
        r.kind   = ROW_WRITE;
        r.wr_val = v;
        return r;
    endfunction

    function automatic sample_t healthy(logic gate, logic safe, logic arm);
        sample_t s;
        s = '0;
        s.sample_valid    = 1'b1;
        s.init_done       = 1'b1;
        s.link_online     = 1'b1;
        s.tasks_healthy   = 1'b1;
        s.devices_healthy = 1'b1;
        s.enable_request  = gate;
        s.safe_position   = safe;
        s.arm_event       = arm;
        return s;
    endfunction

    function automatic sample_t spoil(sample_t s);
        sample_t r;
        r = s;
        case ($urandom_range(0, 5))
            0: r.init_done       = 1'b0;
            1: r.link_online     = 1'b0;
            2: r.estop           = 1'b1;
            3: r.tasks_healthy   = 1'b0;
            4: r.devices_healthy = 1'b0;
            default: r.sample_valid = 1'b0;
        endcase
        return r;
    endfunction

    function automatic sample_t noise();
        sample_t s;
        s = sample_t'($urandom_range(0, 511));
        s.sample_valid = ($urandom_range(0, 7) != 0);
        return s;
    endfunction

    function automatic logic coin();
        return logic'($urandom_range(0, 1));
    endfunction

    task automatic send(sample_t s, logic typed, result_t want);
        result_t pred;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 5))
            begin
                @(negedge clk);
                sample_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= s;
        do
            @(posedge clk);
        while (!(sample_ch.valid && sample_ch.ready));
        pred = interlock_step(s);
        pending_results.push_back(typed ? want : pred);
        n_samples++;
    endtask

    task automatic send_rand(sample_t s);
        send(s, 1'b0, '0);
    endtask

    task automatic write_rearm(logic v);
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        m_rearm = v;
        n_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // well-formed arming sequences dominate; the rest is broken runs and noise
    task automatic run_random(int target);
        int      sent;
        sample_t s;
        sent = 0;
        while (sent < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        send_rand(healthy(1'b0, 1'b1, coin()));
                        sent++;
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_rand(healthy(1'b1, 1'b1, 1'b0));
                        sent++;
                    end
                    send_rand(healthy(1'b1, 1'b1, 1'b1));
                    sent++;
                    repeat ($urandom_range(1, 8))
                    begin
                        s = healthy(1'b1, coin(), coin());
                        if ($urandom_range(0, 11) == 0)
                            s = spoil(s);
                        send_rand(s);
                        sent++;
                    end
                    s = coin() ? healthy(1'b0, coin(), coin()) : spoil(healthy(1'b1, 1'b1, 1'b0));
                    send_rand(s);
                    sent++;
                end
                6, 7:
                begin
                    repeat ($urandom_range(2, 6))
                    begin
                        s = healthy(coin(), coin(), coin());
                        if ($urandom_range(0, 2) == 0)
                            s = spoil(s);
                        if ($urandom_range(0, 3) == 0)
                            s = spoil(s);
                        send_rand(s);
                        sent++;
                    end
                end
                default:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        send_rand(noise());
                        sent++;
                    end
                end
            endcase
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result %h", $realtime, result_ch.data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.data.changed        !== want.changed
                 || result_ch.data.safety_state   !== want.safety_state
                 || result_ch.data.reason_bits    !== want.reason_bits
                 || result_ch.data.output_allowed !== want.output_allowed
                 || result_ch.data.transitions    !== want.transitions)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] mismatch exp chg=%0b st=%0d rs=%h ok=%0b n=%0d got chg=%0b st=%0d rs=%h ok=%0b n=%0d",
                                 $realtime, want.changed, want.safety_state,
                                 want.reason_bits, want.output_allowed, want.transitions,
                                 result_ch.data.changed, result_ch.data.safety_state,
                                 result_ch.data.reason_bits, result_ch.data.output_allowed,
                                 result_ch.data.transitions);
                end
            end
        end
    end

    // result-side stalls
    initial
    begin
        int n;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 5);
                repeat (n)
                begin
                    @(negedge clk);
                    result_ch.ready <= 1'b0;
                end
            end
            else
            begin
                @(negedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #5ms;
        $display("FAIL safety_arm_interlock");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        rst_n           = 1'b0;
        calm            = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = 1'b0;
        mismatches      = 0;
        n_samples       = 0;
        n_results       = 0;
        n_writes        = 0;
        m_state         = ST_BOOT;
        m_reasons       = REASONS_RESET;
        m_perm          = 1'b0;
        m_safe_seen     = 1'b0;
        m_rearm         = 1'b1;
        m_count         = 32'd0;

        // order: valid init link estop task dev gate safe arm
        plan.push_back(row_known(9'b1_0_1_0_1_1_0_0_0, '{changed: 1'b1,
            safety_state: ST_DISARMED, reason_bits: REASONS_RESET,
            output_allowed: 1'b0, transitions: 32'd1}));
        plan.push_back(row_known(9'b0_1_1_1_1_1_1_1_1, '{changed: 1'b1,
            safety_state: ST_STOPPED, reason_bits: REASONS_INVALID,
            output_allowed: 1'b0, transitions: 32'd2}));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_0_1_0));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_1_1_0));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_1_1_1));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_1_0_0));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_1_0_1));
        plan.push_back(row_smp(9'b1_1_1_1_1_1_1_1_1));
        plan.push_back(row_smp(9'b0_0_0_0_0_0_0_0_0));
        plan.push_back(row_smp(9'b1_0_0_0_0_0_0_0_0));
        plan.push_back(row_smp(9'b1_0_0_1_0_0_0_0_0));
        plan.push_back(row_smp(9'b1_1_0_0_1_1_0_1_0));
        plan.push_back(row_smp(9'b1_1_1_1_1_1_0_1_0));
        plan.push_back(row_smp(9'b1_1_1_0_0_1_0_1_0));
        plan.push_back(row_smp(9'b1_1_1_0_1_0_0_1_0));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_1_1_1));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_0_1_0));
        plan.push_back(row_smp(9'b1_1_1_0_0_1_1_1_1));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_1_1_1));
        plan.push_back(row_wr(1'b0));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_1_0_0));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_0_0_0));
        plan.push_back(row_smp(9'b0_1_1_0_1_1_1_0_0));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_1_0_0));
        plan.push_back(row_wr(1'b1));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_1_0_0));
        plan.push_back(row_smp(9'b1_1_1_0_1_1_0_0_0));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
                write_rearm(plan[i].wr_val);
            else
                send(plan[i].smp, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < 6; p++)
        begin
            write_rearm(logic'(p % 2));
            if (p == 5)
                calm = 1'b1;
            run_random(240);
        end

        @(negedge clk);
        sample_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0d results never arrived", pending_results.size());
        end

        $display("Covered %0d samples, %0d results, %0d rearm writes (both settings).",
                 n_samples, n_results, n_writes);
        $display("Arming sequences, fault injection, invalid samples and random noise.");
        if (mismatches == 0)
            $display("PASS safety_arm_interlock");
        else
            $display("FAIL safety_arm_interlock");
        $finish;
    end

endmodule

`default_nettype wire
